/* sv/vlg_pkg.sv */
// Package for the voice load governor: types, register codes and reset constants.
`default_nettype none
package vlg_pkg;

    localparam int unsigned NUM_W  = 39;
    localparam int unsigned DEN_W  = 32;
    localparam int unsigned LOAD_W = 14;
    localparam int unsigned CFG_W  = 16;

    localparam logic [LOAD_W-1:0] LOAD_MAX      = 14'd16383;
    localparam logic [7:0]        CUT_THRESHOLD = 8'd24;
    localparam logic [7:0]        LIMIT_RESET   = 8'd64;

    localparam logic [15:0] RST_WINDOW_SAMPLES    = 16'd4800;
    localparam logic [15:0] RST_CYCLES_PER_SAMPLE = 16'd6750;
    localparam logic [7:0]  RST_VOICE_CEILING     = 8'd64;
    localparam logic [6:0]  RST_HIGH_LOAD_PCT     = 7'd70;
    localparam logic [6:0]  RST_LOW_LOAD_PCT      = 7'd45;
    localparam logic [6:0]  RST_TARGET_LOAD_PCT   = 7'd60;
    localparam logic [7:0]  RST_MIN_VOICES        = 8'd16;
    localparam logic [12:0] RST_LOW_QUEUE_FRAMES  = 13'd1024;

    typedef enum logic [2:0] {
        CFG_WINDOW_SAMPLES    = 3'd0,
        CFG_CYCLES_PER_SAMPLE = 3'd1,
        CFG_VOICE_CEILING     = 3'd2,
        CFG_HIGH_LOAD_PCT     = 3'd3,
        CFG_LOW_LOAD_PCT      = 3'd4,
        CFG_TARGET_LOAD_PCT   = 3'd5,
        CFG_MIN_VOICES        = 3'd6,
        CFG_LOW_QUEUE_FRAMES  = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_LOAD_GO,
        ST_LOAD_WAIT,
        ST_LIM_GO,
        ST_LIM_WAIT,
        ST_DONE
    } t_vlg_state;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_RUN,
        DV_DONE
    } t_div_state;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [LOAD_W-1:0] quo;
    } t_div_rsp;

endpackage
`default_nettype wire

/* sv/vlg_div.sv */
// Bit-serial restoring divider with a 14-bit saturating quotient.
`default_nettype none
module vlg_div
    import vlg_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    t_div_state r_state, n_state;
    logic [NUM_W-1:0]        r_rem;
    logic [DEN_W+LOAD_W-2:0] r_dvs;
    logic [LOAD_W-1:0]       r_quo;
    logic [3:0]              r_cnt;

    logic sat;
    logic fits;

    // quotient of 2^14 or more saturates; a zero divisor lands here too
    assign sat  = {7'b0, i_req.num} >= {i_req.den, 14'b0};
    assign fits = {6'b0, r_rem} >= r_dvs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_rsp.done = 1'b0;
        o_rsp.quo  = r_quo;
        case (r_state)
            DV_IDLE: begin
                if (i_req.start) begin
                    n_state = sat ? DV_DONE : DV_RUN;
                end
            end
            DV_RUN: begin
                if (r_cnt == 4'd0) begin
                    n_state = DV_DONE;
                end
            end
            DV_DONE: begin
                o_rsp.done = 1'b1;
                n_state = DV_IDLE;
            end
            default: n_state = DV_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            DV_IDLE: begin
                if (i_req.start) begin
                    r_rem <= i_req.num;
                    r_dvs <= {i_req.den, 13'b0};
                    r_cnt <= 4'(LOAD_W - 1);
                    r_quo <= sat ? LOAD_MAX : '0;
                end
            end
            DV_RUN: begin
                if (fits) begin
                    r_rem <= r_rem - r_dvs[NUM_W-1:0];
                end
                r_quo <= {r_quo[LOAD_W-2:0], fits};
                r_dvs <= r_dvs >> 1;
                r_cnt <= r_cnt - 4'd1;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

/* sv/voice_load_governor.sv */
// Top level of the voice load governor: accumulators, control sequencer and result register.
// Usage:
//   Input channel (i_in_valid / o_in_stall) takes one render-batch report per
//   transaction; output channel (o_out_valid / i_out_stall) returns one result
//   per report: voice limit, last load percent and a window-closed flag.
//   Configuration registers are written through i_cfg_we / i_cfg_idx / i_cfg_wdata;
//   the user must write them only while the block is idle; the block does not enforce this.
// Sequence:
//   A report that does not close a window goes from ST_DONE to the output register once
//   that register is free; the input reopens as it is loaded. A closing report runs a
//   bit-serial multiply for the divisor (ST_MUL), then a serial divide for the 14-bit
//   load (ST_LOAD_GO / ST_LOAD_WAIT), and for the sample engine, when the load is above
//   the high mark and active voices exceed the minimum, a second serial divide for the
//   scaled limit. The input stays stalled until each report is through.
// Reset:
//   Synchronous, active low. Accumulators and load clear, the limit goes to 64,
//   configuration returns to its defaults, the output register empties.
// Stall:
//   A held result waits in the output register; one more report is accepted and
//   worked on, then the input stalls until the output register is taken.
`default_nettype none
module voice_load_governor
    import vlg_pkg::*;
#(
    parameter int MAX_BATCH = 512
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [31:0] i_batch_cycles,
    input  wire logic [9:0]  i_batch_samples,
    input  wire logic [12:0] i_queued_frames,
    input  wire logic [7:0]  i_active_voices,
    input  wire logic        i_engine_is_sample,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_voice_limit,
    output logic [13:0]      o_load_pct,
    output logic             o_window_done,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_wdata
);

    localparam logic [12:0] MaxBatchW = 13'(MAX_BATCH);

    // configuration
    logic [15:0] r_window_samples;
    logic [15:0] r_cycles_per_sample;
    logic [7:0]  r_voice_ceiling;
    logic [6:0]  r_high_load_pct;
    logic [6:0]  r_low_load_pct;
    logic [6:0]  r_target_load_pct;
    logic [7:0]  r_min_voices;
    logic [12:0] r_low_queue_frames;

    // state
    t_vlg_state r_state, n_state;
    logic [31:0] r_cycle_sum;
    logic [15:0] r_sample_sum;
    logic [7:0]  r_limit;
    logic [13:0] r_last_load;

    // per-report work registers
    logic [7:0]  r_prior;
    logic [7:0]  r_active;
    logic        r_engine;
    logic        r_done;
    logic [14:0] r_prod;
    logic [31:0] r_cyc_work;
    logic [15:0] r_mplr;
    logic [31:0] r_den;
    logic [NUM_W-1:0] r_num;
    logic [3:0]  r_cnt;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic        accept;
    logic        out_free;
    logic [9:0]  smp_clamp;
    logic [31:0] cyc_new;
    logic [15:0] smp_new;
    logic        cut;
    logic [7:0]  cut_lim;
    logic        close;
    logic        need_scale;
    logic [8:0]  grow_lim;
    logic [7:0]  keep_lim;
    logic [13:0] scale_lim;

    assign accept    = i_in_valid && (r_state == ST_IDLE);
    assign out_free  = !o_out_valid || !i_out_stall;

    assign smp_clamp = ({3'b0, i_batch_samples} > MaxBatchW) ? MaxBatchW[9:0]
                                                            : i_batch_samples;
    assign cyc_new   = r_cycle_sum + i_batch_cycles;
    assign smp_new   = r_sample_sum + {6'b0, smp_clamp};
    assign cut       = (i_queued_frames < r_low_queue_frames) && i_engine_is_sample;
    assign cut_lim   = (i_active_voices > CUT_THRESHOLD)
                     ? i_active_voices - {2'b0, i_active_voices[7:2]}
                     : r_min_voices;
    assign close     = smp_new >= r_window_samples;

    assign need_scale = (div_rsp.quo > {7'b0, r_high_load_pct}) && (r_active > r_min_voices);
    assign grow_lim   = ((div_rsp.quo < {7'b0, r_low_load_pct}) && (r_prior < r_voice_ceiling))
                      ? {1'b0, r_prior} + 9'd4 : {1'b0, r_prior};
    assign keep_lim   = (grow_lim > {1'b0, r_voice_ceiling}) ? r_voice_ceiling : grow_lim[7:0];
    assign scale_lim  = (div_rsp.quo < {6'b0, r_min_voices}) ? {6'b0, r_min_voices}
                                                             : div_rsp.quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_samples    <= RST_WINDOW_SAMPLES;
            r_cycles_per_sample <= RST_CYCLES_PER_SAMPLE;
            r_voice_ceiling     <= RST_VOICE_CEILING;
            r_high_load_pct     <= RST_HIGH_LOAD_PCT;
            r_low_load_pct      <= RST_LOW_LOAD_PCT;
            r_target_load_pct   <= RST_TARGET_LOAD_PCT;
            r_min_voices        <= RST_MIN_VOICES;
            r_low_queue_frames  <= RST_LOW_QUEUE_FRAMES;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_WINDOW_SAMPLES:    r_window_samples    <= i_cfg_wdata;
                CFG_CYCLES_PER_SAMPLE: r_cycles_per_sample <= i_cfg_wdata;
                CFG_VOICE_CEILING:     r_voice_ceiling     <= i_cfg_wdata[7:0];
                CFG_HIGH_LOAD_PCT:     r_high_load_pct     <= i_cfg_wdata[6:0];
                CFG_LOW_LOAD_PCT:      r_low_load_pct      <= i_cfg_wdata[6:0];
                CFG_TARGET_LOAD_PCT:   r_target_load_pct   <= i_cfg_wdata[6:0];
                CFG_MIN_VOICES:        r_min_voices        <= i_cfg_wdata[7:0];
                CFG_LOW_QUEUE_FRAMES:  r_low_queue_frames  <= i_cfg_wdata[12:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        div_req.start = 1'b0;
        div_req.num   = r_num;
        div_req.den   = r_den;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = close ? ST_MUL : ST_DONE;
                end
            end
            ST_MUL: begin
                if (r_cnt == 4'd0) begin
                    n_state = ST_LOAD_GO;
                end
            end
            ST_LOAD_GO: begin
                div_req.start = 1'b1;
                n_state = ST_LOAD_WAIT;
            end
            ST_LOAD_WAIT: begin
                if (div_rsp.done) begin
                    n_state = (r_engine && need_scale) ? ST_LIM_GO : ST_DONE;
                end
            end
            ST_LIM_GO: begin
                div_req.start = 1'b1;
                div_req.num   = {24'b0, r_prod};
                div_req.den   = {18'b0, r_last_load};
                n_state = ST_LIM_WAIT;
            end
            ST_LIM_WAIT: begin
                if (div_rsp.done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cycle_sum  <= '0;
            r_sample_sum <= '0;
            r_limit      <= LIMIT_RESET;
            r_last_load  <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_cycle_sum  <= close ? '0 : cyc_new;
                        r_sample_sum <= close ? '0 : smp_new;
                        if (cut) begin
                            r_limit <= cut_lim;
                        end
                    end
                end
                ST_LOAD_WAIT: begin
                    if (div_rsp.done) begin
                        r_last_load <= div_rsp.quo;
                        if (r_engine && !need_scale) begin
                            r_limit <= keep_lim;
                        end
                    end
                end
                ST_LIM_WAIT: begin
                    if (div_rsp.done) begin
                        r_limit <= (scale_lim > {6'b0, r_voice_ceiling}) ? r_voice_ceiling
                                                                         : scale_lim[7:0];
                    end
                end
                default: ;
            endcase
        end
    end

    // work registers: no reset needed
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    r_prior    <= r_limit;
                    r_active   <= i_active_voices;
                    r_engine   <= i_engine_is_sample;
                    r_done     <= close;
                    r_prod     <= {7'b0, i_active_voices} * {8'b0, r_target_load_pct};
                    r_cyc_work <= cyc_new;
                    r_mplr     <= smp_new;
                    r_den      <= '0;
                    r_cnt      <= 4'd15;
                end
            end
            ST_MUL: begin
                // one multiplier bit per cycle, MSB first
                r_den  <= {r_den[30:0], 1'b0} + (r_mplr[15] ? {16'b0, r_cycles_per_sample}
                                                             : 32'b0);
                r_mplr <= {r_mplr[14:0], 1'b0};
                r_cnt  <= r_cnt - 4'd1;
                // times 100 as 64 + 32 + 4
                r_num  <= {1'b0, r_cyc_work, 6'b0} + {2'b0, r_cyc_work, 5'b0}
                        + {5'b0, r_cyc_work, 2'b0};
            end
            default: ;
        endcase
    end

    logic        r_out_valid;
    logic [7:0]  r_out_limit;
    logic [13:0] r_out_load;
    logic        r_out_done;

    assign o_out_valid   = r_out_valid;
    assign o_voice_limit = r_out_limit;
    assign o_load_pct    = r_out_load;
    assign o_window_done = r_out_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            r_out_limit <= r_limit;
            r_out_load  <= r_last_load;
            r_out_done  <= r_done;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

    vlg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

endmodule
`default_nettype wire

/* sv/vlg_checker.sv */
// Port-level checker for the voice load governor, bound to the top level.
`default_nettype none
module vlg_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [7:0]  o_voice_limit,
    input wire logic [13:0] o_load_pct,
    input wire logic        o_window_done
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_voice_limit)
            && $stable(o_load_pct) && $stable(o_window_done)))
        else $error("output transaction changed while stalled");

    // one report at a time: an accepted transaction closes the input
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input open right after an accepted transaction");

    // a new result appears only out of a busy cycle
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_in_stall && !i_in_valid) |=> !$rose(o_out_valid))
        else $error("result appeared without a report in work");

    // a result comes up on the output only while the input is stalled, never while a report can still be accepted
    a_no_new_while_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result loaded while input was open");

endmodule

bind voice_load_governor vlg_checker u_vlg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_voice_limit (o_voice_limit),
    .o_load_pct    (o_load_pct),
    .o_window_done (o_window_done)
);
`default_nettype wire
